// ===== hdl/dhb_pkg.sv =====
// ----------------------------------------------------------------------------
// dhb_pkg
// Types and constants shared by the dual H-bridge PWM slew ramp block.
// ----------------------------------------------------------------------------
package dhb_pkg;

  localparam int DUTY_W  = 8;
  localparam int MAG_W   = 8;
  localparam int DZ_W    = 7;
  localparam int WD_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

  localparam logic [DZ_W-1:0]   DEADZONE_RST = 7'd1;
  localparam logic [WD_W-1:0]   WD_LIMIT_RST = 7'd75;
  localparam logic [DUTY_W-1:0] MIN_DUTY_RST = 8'd10;
  localparam logic [DUTY_W-1:0] MAX_DUTY_RST = 8'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE       = 3'd0,
    CFG_WATCHDOG_LIMIT = 3'd1,
    CFG_MIN_DUTY       = 3'd2,
    CFG_MAX_DUTY       = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              watchdog_kick;
    logic signed [7:0] left_command;
    logic signed [7:0] right_command;
  } in_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_forward_duty;
    logic [DUTY_W-1:0] left_reverse_duty;
    logic [DUTY_W-1:0] right_forward_duty;
    logic [DUTY_W-1:0] right_reverse_duty;
    logic              watchdog_expired;
  } out_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fwd;
    logic [DUTY_W-1:0] rev;
    logic              reversed;
  } side_t;

  typedef struct packed {
    logic [DUTY_W-1:0] min_duty;
    logic [DUTY_W-1:0] max_duty;
  } duty_lim_t;

endpackage

// ===== hdl/dhb_side.sv =====
// ----------------------------------------------------------------------------
// dhb_side
// Target duty and one-step slew update for one H-bridge side, with
// ramp-down to zero before a direction change.
// ----------------------------------------------------------------------------
module dhb_side import dhb_pkg::*; #(
  parameter int SPEED_GAIN = 4
) (
  input  side_t            cur,
  input  logic             neg,
  input  logic [MAG_W-1:0] mag,
  input  logic             active,
  input  duty_lim_t        lim,
  output side_t            nxt
);

  localparam int GAIN_W = $clog2(SPEED_GAIN + 1);
  localparam int PROD_W = MAG_W + GAIN_W;

  logic [PROD_W-1:0] product;
  logic [DUTY_W-1:0] sat;
  logic [DUTY_W-1:0] target;
  logic [DUTY_W-1:0] drive;
  logic [DUTY_W-1:0] stepped;
  logic [DUTY_W-1:0] fwd_dn;
  logic [DUTY_W-1:0] rev_dn;

  assign product = PROD_W'(mag) * PROD_W'(SPEED_GAIN);
  assign sat = (product > PROD_W'(DUTY_MAX)) ? DUTY_MAX : product[DUTY_W-1:0];

  always_comb begin
    if (!active) begin
      target = '0;
    end else if (sat < lim.min_duty) begin
      target = '0;
    end else if (sat > lim.max_duty) begin
      target = lim.max_duty;
    end else begin
      target = sat;
    end
  end

  assign drive = neg ? cur.rev : cur.fwd;

  always_comb begin
    if (drive < target) begin
      stepped = drive + 1'b1;
    end else if (drive > target) begin
      stepped = drive - 1'b1;
    end else begin
      stepped = drive;
    end
  end

  assign fwd_dn = (cur.fwd != '0) ? cur.fwd - 1'b1 : '0;
  assign rev_dn = (cur.rev != '0) ? cur.rev - 1'b1 : '0;

  always_comb begin
    nxt = cur;
    if (neg == cur.reversed) begin
      nxt.fwd = neg ? '0 : stepped;
      nxt.rev = neg ? stepped : '0;
    end else begin
      nxt.fwd = fwd_dn;
      nxt.rev = rev_dn;
      if (fwd_dn == '0 && rev_dn == '0) begin
        nxt.reversed = neg;
      end
    end
  end

endmodule

// ===== hdl/dual_hbridge_pwm_slew_ramp.sv =====
// Latency: a tick's result is registered at the edge that accepts it and is
// offered from the next cycle on.
// Throughput: one tick per cycle; the single output register stalls the input
// only while it holds a result that the sink has not taken.
// Reset (rst, synchronous): duties, direction flags and watchdog count clear,
// registers return to deadzone 1, limit 75, min 10, max 250.
// ----------------------------------------------------------------------------
// dual_hbridge_pwm_slew_ramp
// Watchdog-gated, slew-limited dual H-bridge PWM duty generator.
// ----------------------------------------------------------------------------
module dual_hbridge_pwm_slew_ramp import dhb_pkg::*; #(
  parameter int SPEED_GAIN = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DZ_W-1:0] deadzone;
  logic [WD_W-1:0] watchdog_limit;
  duty_lim_t       lim;

  logic [WD_W-1:0] silence_count;
  logic [WD_W-1:0] silence_count_next;
  side_t           left_side;
  side_t           right_side;
  side_t           left_side_next;
  side_t           right_side_next;

  logic             in_accept;
  logic             expired;
  logic             active;
  logic             left_neg;
  logic             right_neg;
  logic [MAG_W-1:0] left_mag;
  logic [MAG_W-1:0] right_mag;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone       <= DEADZONE_RST;
      watchdog_limit <= WD_LIMIT_RST;
      lim.min_duty   <= MIN_DUTY_RST;
      lim.max_duty   <= MAX_DUTY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEADZONE:       deadzone       <= cfg_data[DZ_W-1:0];
        CFG_WATCHDOG_LIMIT: watchdog_limit <= cfg_data[WD_W-1:0];
        CFG_MIN_DUTY:       lim.min_duty   <= cfg_data[DUTY_W-1:0];
        CFG_MAX_DUTY:       lim.max_duty   <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_data.watchdog_kick) begin
      silence_count_next = '0;
    end else if (silence_count < watchdog_limit) begin
      silence_count_next = silence_count + 1'b1;
    end else begin
      silence_count_next = silence_count;
    end
  end

  assign expired   = silence_count_next >= watchdog_limit;
  assign left_neg  = in_data.left_command[7];
  assign right_neg = in_data.right_command[7];
  assign left_mag  = left_neg ? MAG_W'(-in_data.left_command) : MAG_W'(in_data.left_command);
  assign right_mag = right_neg ? MAG_W'(-in_data.right_command)
                               : MAG_W'(in_data.right_command);
  assign active = ~expired & ((left_mag > MAG_W'(deadzone)) | (right_mag > MAG_W'(deadzone)));

  dhb_side #(.SPEED_GAIN(SPEED_GAIN)) u_left (
    .cur    (left_side),
    .neg    (left_neg),
    .mag    (left_mag),
    .active (active),
    .lim    (lim),
    .nxt    (left_side_next)
  );

  dhb_side #(.SPEED_GAIN(SPEED_GAIN)) u_right (
    .cur    (right_side),
    .neg    (right_neg),
    .mag    (right_mag),
    .active (active),
    .lim    (lim),
    .nxt    (right_side_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_count <= '0;
      left_side     <= '0;
      right_side    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_accept) begin
        silence_count <= silence_count_next;
        left_side     <= left_side_next;
        right_side    <= right_side_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.left_forward_duty  <= left_side_next.fwd;
      out_data.left_reverse_duty  <= left_side_next.rev;
      out_data.right_forward_duty <= right_side_next.fwd;
      out_data.right_reverse_duty <= right_side_next.rev;
      out_data.watchdog_expired   <= expired;
    end
  end

  a_one_side_driven: assert property (@(posedge clk) disable iff (rst)
    !(left_side.fwd != '0 && left_side.rev != '0) &&
    !(right_side.fwd != '0 && right_side.rev != '0))
    else $error("both halves of an H-bridge side driven");

  a_slew_one_step: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (left_side.fwd == $past(left_side.fwd) ||
                   left_side.fwd == $past(left_side.fwd) + 1'b1 ||
                   left_side.fwd == $past(left_side.fwd) - 1'b1))
    else $error("left forward duty moved more than one step");

  a_kick_clears_expiry: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.watchdog_kick && watchdog_limit != '0)
      |=> !out_data.watchdog_expired)
    else $error("watchdog expired right after a kick");

endmodule
